/* rtl/ramt_pkg.sv */
// ----------------------------------------------------------------------------
// ramt_pkg
// Types, constants and helper functions shared by the memory test engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ramt_pkg;

  localparam int unsigned BATCH_LEN = 2048;
  localparam int unsigned SLOT_W    = $clog2(BATCH_LEN);

  localparam logic [31:0] SEED_MIX = 32'h4698_a74f;
  localparam logic [31:0] ERR_MAX  = 32'hffff_ffff;

  localparam logic [31:0] SEED_RESET  = 32'h3285_a83d;
  localparam logic [5:0]  SIZE_RESET  = 6'd28;
  localparam logic [31:0] LIMIT_RESET = 32'h0080_0000;
  localparam logic [15:0] BATCH_RESET = 16'd512;

  typedef enum logic [1:0] {
    REG_SEED  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_LIMIT = 2'd2,
    REG_BATCH = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_REQUEST = 2'd1,
    FUNC_RETURN  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } access_kind_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [31:0] byte_address;
    logic [7:0]  write_byte;
    logic        mismatch;
    logic [31:0] error_total;
    logic        finished;
  } out_item_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic logic [31:0] address_mask(input logic [5:0] size_log2);
    logic [31:0] size_mask;
    if (size_log2 >= 6'd32) begin
      size_mask = ERR_MAX;
    end else begin
      size_mask = (32'd1 << size_log2[4:0]) - 32'd1;
    end
    return size_mask & ~(32'(BATCH_LEN) - 32'd1);
  endfunction

endpackage

`default_nettype wire

/* rtl/ramt_in_if.sv */
// ----------------------------------------------------------------------------
// ramt_in_if
// Request channel of the memory test engine: function code and read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ramt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] read_byte;

  modport source (output valid, output func, output read_byte, input ready);
  modport sink (input valid, input func, input read_byte, output ready);
endinterface

`default_nettype wire

/* rtl/ramt_out_if.sv */
// ----------------------------------------------------------------------------
// ramt_out_if
// Result channel of the memory test engine: one access or status item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ramt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  access_kind;
  logic [31:0] byte_address;
  logic [7:0]  write_byte;
  logic        mismatch;
  logic [31:0] error_total;
  logic        finished;

  modport source (output valid, output access_kind, output byte_address,
                  output write_byte, output mismatch, output error_total,
                  output finished, input ready);
  modport sink (input valid, input access_kind, input byte_address,
                input write_byte, input mismatch, input error_total,
                input finished, output ready);
endinterface

`default_nettype wire

/* rtl/random_access_memory_test_engine.sv */
// ----------------------------------------------------------------------------
// random_access_memory_test_engine
// Random-address memory self-test sequencer with a xorshift32 generator.
//
// The in_ch channel carries one item per command: start a test, request the
// next access slot, or return the byte read for the last read access. The
// out_ch channel returns exactly one item for each accepted input: the access
// to perform (none, write or read), its byte address and write data, the
// mismatch flag for a returned byte, the saturating error count and the
// finished flag. Registers are set through cfg_we, cfg_index and cfg_data; the
// user must set them only while the block is idle; the block does not enforce it.
// Each item is handled in the cycle it is accepted and its result is registered
// into the result register, or into the skid register while a result waits; one
// item per cycle is sustained while the receiver keeps taking results.
// A two-entry output buffer (result register plus skid register) lets the
// block take an item while a result waits; in_ch.ready drops only when both
// entries are full, so a stalled receiver holds the block after two items.
// Reset restores the register defaults, idles the test and empties the
// output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module random_access_memory_test_engine
  import ramt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  ramt_in_if.sink     in_ch,
  ramt_out_if.source  out_ch
);

  logic [31:0] seed_value;
  logic [5:0]  ram_size_log2;
  logic [31:0] low_limit;
  logic [15:0] batch_count;

  logic [31:0]       prng_state, prng_state_next;
  logic [31:0]       saved_prng, saved_prng_next;
  logic              check_phase, check_phase_next;
  logic [SLOT_W-1:0] slot_index, slot_index_next;
  logic [15:0]       batches_done, batches_done_next;
  logic [7:0]        expected_byte, expected_byte_next;
  logic [31:0]       error_counter, error_counter_next;
  logic              running, running_next;
  logic              read_pending, read_pending_next;

  out_item_t   result;
  out_item_t   out_data, skid_data;
  logic        out_valid, skid_valid;
  logic        in_fire, out_fire;

  logic [31:0] draw_a, draw_b, addr, prng_tmp;
  logic        do_finish;

  assign in_ch.ready = !skid_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value    <= SEED_RESET;
      ram_size_log2 <= SIZE_RESET;
      low_limit     <= LIMIT_RESET;
      batch_count   <= BATCH_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SEED:  seed_value    <= cfg_data;
        REG_SIZE:  ram_size_log2 <= cfg_data[5:0];
        REG_LIMIT: low_limit     <= cfg_data;
        REG_BATCH: batch_count   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prng_state_next    = prng_state;
    saved_prng_next    = saved_prng;
    check_phase_next   = check_phase;
    slot_index_next    = slot_index;
    batches_done_next  = batches_done;
    expected_byte_next = expected_byte;
    error_counter_next = error_counter;
    running_next       = running;
    read_pending_next  = read_pending;
    do_finish          = 1'b0;
    result             = '0;

    draw_a   = xorshift32(prng_state);
    draw_b   = xorshift32(draw_a);
    addr     = (draw_a & address_mask(ram_size_log2)) + 32'(slot_index);
    prng_tmp = prng_state;

    case (func_t'(in_ch.func))
      FUNC_START: begin
        prng_tmp = seed_value ^ SEED_MIX;
        if (prng_tmp == 32'd0) begin
          prng_tmp = SEED_MIX;
        end
        saved_prng_next    = prng_tmp;
        check_phase_next   = 1'b0;
        slot_index_next    = '0;
        batches_done_next  = '0;
        expected_byte_next = '0;
        error_counter_next = '0;
        read_pending_next  = 1'b0;
        running_next       = (batch_count != 16'd0);
      end
      FUNC_REQUEST: begin
        if (running && !read_pending) begin
          result.byte_address = addr;
          if (addr < low_limit) begin
            prng_tmp  = draw_a;
            do_finish = 1'b1;
          end else if (!check_phase) begin
            prng_tmp          = draw_b;
            result.access_kind = KIND_WRITE;
            result.write_byte  = draw_b[7:0];
            do_finish         = 1'b1;
          end else begin
            prng_tmp           = draw_b;
            result.access_kind = KIND_READ;
            expected_byte_next = draw_b[7:0];
            read_pending_next  = 1'b1;
          end
        end
      end
      FUNC_RETURN: begin
        if (running && read_pending) begin
          read_pending_next = 1'b0;
          if (in_ch.read_byte != expected_byte) begin
            result.mismatch = 1'b1;
            if (error_counter != ERR_MAX) begin
              error_counter_next = error_counter + 32'd1;
            end
          end
          do_finish = 1'b1;
        end
      end
      default: ;
    endcase

    prng_state_next = prng_tmp;

    if (do_finish) begin
      if (slot_index == SLOT_W'(BATCH_LEN - 1)) begin
        slot_index_next = '0;
        if (!check_phase) begin
          check_phase_next = 1'b1;
          prng_state_next  = saved_prng;
        end else begin
          check_phase_next  = 1'b0;
          batches_done_next = batches_done + 16'd1;
          saved_prng_next   = prng_tmp;
          if (batches_done_next >= batch_count) begin
            running_next = 1'b0;
          end
        end
      end else begin
        slot_index_next = slot_index + SLOT_W'(1);
      end
    end

    result.error_total = error_counter_next;
    result.finished    = !running_next && (batches_done_next >= batch_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prng_state    <= SEED_MIX;
      saved_prng    <= '0;
      check_phase   <= 1'b0;
      slot_index    <= '0;
      batches_done  <= '0;
      expected_byte <= '0;
      error_counter <= '0;
      running       <= 1'b0;
      read_pending  <= 1'b0;
    end else if (in_fire) begin
      prng_state    <= prng_state_next;
      saved_prng    <= saved_prng_next;
      check_phase   <= check_phase_next;
      slot_index    <= slot_index_next;
      batches_done  <= batches_done_next;
      expected_byte <= expected_byte_next;
      error_counter <= error_counter_next;
      running       <= running_next;
      read_pending  <= read_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= in_fire;
        end else begin
          out_valid <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_fire) begin
          skid_data <= result;
        end
      end else if (in_fire) begin
        out_data <= result;
      end
    end else if (in_fire) begin
      skid_data <= result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.access_kind  = out_data.access_kind;
  assign out_ch.byte_address = out_data.byte_address;
  assign out_ch.write_byte   = out_data.write_byte;
  assign out_ch.mismatch     = out_data.mismatch;
  assign out_ch.error_total  = out_data.error_total;
  assign out_ch.finished     = out_data.finished;

endmodule

`default_nettype wire

/* bench/tb_random_access_memory_test_engine.sv */
// ----------------------------------------------------------------------------
// tb_random_access_memory_test_engine
// Self-checking bench for the random-address memory test sequencer.
//
// A directed table runs first. It covers requests and data returns while the
// test is idle, the unused function code, a restart during a running test, a
// zero batch count, the smallest and largest address masks, and a seed that
// cancels the fixed seed constant. Short random rounds follow, each with new
// register settings. A predictor in the bench computes each result item that
// the table does not give, and the bench compares every result item field by
// field. Both channels insert random gaps, with some stretches that have none.
// ----------------------------------------------------------------------------
module tb_random_access_memory_test_engine;
  import ramt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    bit          is_reg;
    reg_index_t  idx;
    logic [31:0] value;
    logic [1:0]  func;
    logic [7:0]  rb;
    bit          given;
    out_item_t   result;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  ramt_in_if  in_ch();
  ramt_out_if out_ch();

  random_access_memory_test_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  logic [31:0] seed_reg      = SEED_RESET;
  logic [5:0]  size_log2_reg = SIZE_RESET;
  logic [31:0] limit_reg     = LIMIT_RESET;
  logic [15:0] batches_reg   = BATCH_RESET;

  logic [31:0] prng          = SEED_MIX;
  logic [31:0] replay_prng   = '0;
  bit          in_read_pass  = 1'b0;
  int unsigned slot          = 0;
  logic [15:0] batches_done  = '0;
  logic [7:0]  want_byte     = '0;
  logic [31:0] miss_tally    = '0;
  bit          test_active   = 1'b0;
  bit          read_outstanding = 1'b0;

  out_item_t   expected_accesses[$];
  plan_row_t   directed_plan[$];
  int unsigned fail_count = 0;
  bit          quiet = 1'b0;

  function automatic logic [31:0] next_random();
    logic [31:0] x;
    x = prng;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    prng = x;
    return x;
  endfunction

  function automatic logic [31:0] slot_mask();
    logic [31:0] size_mask;
    if (size_log2_reg >= 6'd32) begin
      size_mask = 32'hffff_ffff;
    end else begin
      size_mask = (32'd1 << size_log2_reg) - 32'd1;
    end
    return size_mask & ~32'(BATCH_LEN - 1);
  endfunction

  function automatic void advance_slot();
    slot++;
    if (slot == BATCH_LEN) begin
      slot = 0;
      if (!in_read_pass) begin
        in_read_pass = 1'b1;
        prng = replay_prng;
      end else begin
        in_read_pass = 1'b0;
        batches_done = batches_done + 16'd1;
        replay_prng = prng;
        if (batches_done >= batches_reg) begin
          test_active = 1'b0;
        end
      end
    end
  endfunction

  function automatic out_item_t predict_access(input logic [1:0] f, input logic [7:0] rb);
    out_item_t   r;
    logic [31:0] addr;
    logic [31:0] data;
    r = '0;
    case (f)
      FUNC_START: begin
        prng = seed_reg ^ SEED_MIX;
        if (prng == '0) begin
          prng = SEED_MIX;
        end
        replay_prng = prng;
        in_read_pass = 1'b0;
        slot = 0;
        batches_done = '0;
        want_byte = '0;
        miss_tally = '0;
        read_outstanding = 1'b0;
        test_active = (batches_reg != '0);
      end
      FUNC_REQUEST: begin
        if (test_active && !read_outstanding) begin
          addr = (next_random() & slot_mask()) + 32'(slot);
          r.byte_address = addr;
          if (addr < limit_reg) begin
            advance_slot();
          end else if (!in_read_pass) begin
            data = next_random();
            r.access_kind = KIND_WRITE;
            r.write_byte = data[7:0];
            advance_slot();
          end else begin
            data = next_random();
            r.access_kind = KIND_READ;
            want_byte = data[7:0];
            read_outstanding = 1'b1;
          end
        end
      end
      FUNC_RETURN: begin
        if (test_active && read_outstanding) begin
          read_outstanding = 1'b0;
          if (rb != want_byte) begin
            r.mismatch = 1'b1;
            if (miss_tally != ERR_MAX) begin
              miss_tally++;
            end
          end
          advance_slot();
        end
      end
      default: ;
    endcase
    r.error_total = miss_tally;
    r.finished = !test_active && (batches_done >= batches_reg);
    return r;
  endfunction

  function automatic out_item_t status_word(input logic [31:0] errs, input logic fin);
    out_item_t r;
    r = '0;
    r.error_total = errs;
    r.finished = fin;
    return r;
  endfunction

  function automatic void plan_reg(input reg_index_t idx, input logic [31:0] value);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.value = value;
    row.func = FUNC_START;
    row.rb = '0;
    row.given = 1'b0;
    row.result = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_item(input logic [1:0] f, input logic [7:0] rb,
                                    input bit given = 1'b0, input out_item_t result = '0);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.idx = REG_SEED;
    row.value = '0;
    row.func = f;
    row.rb = rb;
    row.given = given;
    row.result = result;
    directed_plan.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEED:  seed_reg = value;
      REG_SIZE:  size_log2_reg = value[5:0];
      REG_LIMIT: limit_reg = value;
      REG_BATCH: batches_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] f, input logic [7:0] rb,
                           input bit given = 1'b0, input out_item_t result = '0);
    int unsigned gap;
    out_item_t   predicted;
    if ($urandom_range(0, 49) == 0) begin
      quiet = !quiet;
    end
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.read_byte <= rb;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_access(f, rb);
    expected_accesses.push_back(given ? result : predicted);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_accesses.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_accesses.size() != 0) begin
      $error("%0d result items never arrived", expected_accesses.size());
      fail_count++;
      expected_accesses.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_sink
    out_item_t   got;
    out_item_t   want;
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.access_kind = out_ch.access_kind;
      got.byte_address = out_ch.byte_address;
      got.write_byte = out_ch.write_byte;
      got.mismatch = out_ch.mismatch;
      got.error_total = out_ch.error_total;
      got.finished = out_ch.finished;
      if (expected_accesses.size() == 0) begin
        $error("result item with no input item waiting for it");
        fail_count++;
      end else begin
        want = expected_accesses.pop_front();
        check_field("access_kind", 32'(want.access_kind), 32'(got.access_kind));
        check_field("byte_address", want.byte_address, got.byte_address);
        check_field("write_byte", 32'(want.write_byte), 32'(got.write_byte));
        check_field("mismatch", 32'(want.mismatch), 32'(got.mismatch));
        check_field("error_total", want.error_total, got.error_total);
        check_field("finished", 32'(want.finished), 32'(got.finished));
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    logic [1:0]  f;
    logic [7:0]  rb;

    in_ch.valid = 1'b0;
    in_ch.func = FUNC_START;
    in_ch.read_byte = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SEED;
    cfg_data = '0;

    plan_item(FUNC_REQUEST, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_RETURN, 8'hff, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_UNUSED, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_START, 8'h55, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_REQUEST, 8'h00);
    plan_item(FUNC_REQUEST, 8'hff);
    plan_item(FUNC_REQUEST, 8'haa);
    plan_item(FUNC_RETURN, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_START, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_REQUEST, 8'h00);
    plan_reg(REG_BATCH, 32'd0);
    plan_item(FUNC_START, 8'h00, 1'b1, status_word(0, 1'b1));
    plan_item(FUNC_REQUEST, 8'h00, 1'b1, status_word(0, 1'b1));
    plan_reg(REG_BATCH, 32'd1);
    plan_reg(REG_SIZE, 32'd11);
    plan_reg(REG_LIMIT, 32'd0);
    plan_reg(REG_SEED, SEED_MIX);
    plan_item(FUNC_START, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_REQUEST, 8'h00);
    plan_item(FUNC_REQUEST, 8'h00);
    plan_reg(REG_SIZE, 32'd63);
    plan_reg(REG_LIMIT, 32'hffff_ffff);
    plan_reg(REG_SEED, 32'd0);
    plan_item(FUNC_START, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_REQUEST, 8'h00);
    plan_item(FUNC_REQUEST, 8'h00);
    plan_reg(REG_SIZE, 32'd32);
    plan_reg(REG_LIMIT, 32'd0);
    plan_reg(REG_SEED, 32'hffff_ffff);
    plan_item(FUNC_START, 8'h00, 1'b1, status_word(0, 1'b0));
    plan_item(FUNC_REQUEST, 8'h00);
    plan_item(FUNC_REQUEST, 8'h00);
    plan_item(FUNC_UNUSED, 8'hff, 1'b1, status_word(0, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        settle();
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        send_item(directed_plan[i].func, directed_plan[i].rb,
                  directed_plan[i].given, directed_plan[i].result);
      end
    end

    for (int round = 0; round < 5; round++) begin
      settle();
      write_reg(REG_SEED, (round == 0) ? SEED_MIX : (round == 1) ? 32'd0 : $urandom);
      write_reg(REG_SIZE, (round == 0) ? 32'd11 : (round == 1) ? 32'd32 :
                          (round == 2) ? 32'd63 : 32'($urandom_range(11, 32)));
      write_reg(REG_LIMIT, (round == 0) ? 32'd0 : (round == 1) ? 32'hffff_ffff :
                           (round == 2) ? $urandom : ($urandom >> $urandom_range(0, 31)));
      write_reg(REG_BATCH, (round == 0) ? 32'd1 : (round == 1) ? 32'hffff :
                           (round == 2) ? 32'd0 : 32'($urandom_range(1, 65535)));
      for (int i = 0; i < 100; i++) begin
        if (i == 50) begin
          settle();
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          f = FUNC_START;
        end else if (pick < 64) begin
          f = FUNC_REQUEST;
        end else if (pick < 94) begin
          f = FUNC_RETURN;
        end else begin
          f = FUNC_UNUSED;
        end
        rb = 8'($urandom_range(0, 255));
        send_item(f, rb);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
